// File: rtl/whip_gesture_detector_core_assert.svh
// Assertion macros for the whip gesture detector core.
`ifndef WHIP_GESTURE_DETECTOR_CORE_ASSERT_SVH
`define WHIP_GESTURE_DETECTOR_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define WGD_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define WGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/wgd_pkg.sv
// Constants and register codes for the whip gesture detector core.
`timescale 1ns / 1ps

package wgd_pkg;

	localparam int HISTORY_DEPTH_DEF = 5;
	localparam int MAP_DEPTH_DEF     = 6;
	localparam int SAMPLE_WIDTH_DEF  = 16;

	localparam int RANGE_W   = 15;
	localparam int TIMEOUT_W = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(850);

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RANGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 1'd1;

	// Q7.8 thresholds
	localparam int FACE_UP_OFFSET = 2509;   // 9.8
	localparam int WHIP_Z_LIMIT   = -2816;  // -11.0
	localparam int SMALL_X_LIMIT  = 1792;   // 7.0
	localparam int AVG_Z_LIMIT    = 1280;   // 5.0

	// Flip threshold 0.7 of full scale, as 7/10
	localparam int FLIP_NUM = 7;
	localparam int FLIP_DEN = 10;

endpackage

// File: rtl/whip_gesture_detector_core.sv
// Whip gesture detector: z history, whip and flip maps, detection timer.
// Sequence: a timer tick goes straight to evaluation; a sample first sums up to DEPTH-1
//   stored entries, adds z, takes the magnitude, divides and sums the updated history.
// One request at a time: a new one is taken only once evaluation has handed its result
//   on (it waits while the last result is unread), as the one shared adder sums the
//   history and runs the restoring divide one quotient bit per cycle.
// Reset: arst_n clears control, counters, maps and the timer at once; history not cleared.
`timescale 1ns / 1ps

module whip_gesture_detector_core import wgd_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int MAP_DEPTH     = MAP_DEPTH_DEF,
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
	localparam int IN_W = ((3 * SAMPLE_WIDTH + 2 + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input request channel
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // accel_x, accel_y, accel_z, orientation_known, face_up
	input  logic                 s_tuser,   // kind: 0 sample, 1 timer tick
	// result channel
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // whip_detected, detecting
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int ZC_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int MC_W  = $clog2(MAP_DEPTH + 1);
	localparam int MAG_W = SW + $clog2(HISTORY_DEPTH);  // |sum| of z and history
	localparam int UW    = MAG_W + 2;                   // shared adder width, signed
	localparam int DC_W  = $clog2(MAG_W);
	localparam int ZW    = SW + 2;                      // room for z minus face-up offset
	localparam int CW    = SW + 6;                      // flip compare products

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;  // sum stored history
	localparam logic [2:0] ST_ZADD = 3'd2;  // add new z
	localparam logic [2:0] ST_ABS  = 3'd3;  // magnitude of the sum
	localparam logic [2:0] ST_DIV  = 3'd4;  // restoring divide by entry count
	localparam logic [2:0] ST_CHK  = 3'd5;  // sum of the updated history
	localparam logic [2:0] ST_EVAL = 3'd6;  // maps, timer, result

	localparam logic signed [ZW-1:0] WHIP_LIM  = ZW'(WHIP_Z_LIMIT);
	localparam logic signed [ZW-1:0] FU_OFFSET = ZW'(FACE_UP_OFFSET);
	localparam logic [SW-1:0]        SMALL_X   = SW'(SMALL_X_LIMIT);

	logic [2:0] state_q;

	// configuration
	logic [RANGE_W-1:0]   range_q;
	logic [TIMEOUT_W-1:0] timeout_q;

	// captured request
	logic                 kind_q;
	logic signed [SW-1:0] x_q, y_q, z_q;
	logic                 ori_q;
	logic                 fu_q;

	// detector state
	logic [SW-1:0]        hist_q [HISTORY_DEPTH];
	logic [ZC_W-1:0]      z_count_q;
	logic [MAP_DEPTH-1:0] whip_bits_q, flip_bits_q;
	logic [MC_W-1:0]      whip_cnt_q, flip_cnt_q;
	logic signed [SW-1:0] prev_x_q, prev_y_q;
	logic                 detect_q;
	logic [TIMEOUT_W-1:0] timer_q;

	// sequencer datapath
	logic [ZC_W-1:0]      zc_sat_q;   // stored entries summed, capped at DEPTH-1
	logic [IDX_W-1:0]     idx_q;
	logic signed [UW-1:0] acc_q;      // sum of stored history
	logic signed [UW-1:0] num_q;      // signed sum including new z
	logic signed [UW-1:0] rem_q;
	logic [MAG_W-1:0]     quo_q;      // dividend in, quotient out
	logic [DC_W-1:0]      dcnt_q;
	logic signed [UW-1:0] chk_q;

	// result register
	logic out_valid_q, out_whip_q, out_det_q;

	logic accept, out_free, out_load;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_EVAL) && out_free;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_det_q, out_whip_q};

	// next count with the cap applied
	logic [ZC_W-1:0] zc_in, zc_new;
	assign zc_in  = (z_count_q > ZC_W'(HISTORY_DEPTH - 1)) ? ZC_W'(HISTORY_DEPTH - 1)
		: z_count_q;
	assign zc_new = zc_sat_q + ZC_W'(1);

	// ---- shared adder / subtractor ----
	logic signed [UW-1:0] ua, ub, ur;
	logic                 usub;
	assign ur = usub ? (ua - ub) : (ua + ub);

	logic signed [UW-1:0] rem_sh;
	assign rem_sh = {rem_q[UW-2:0], quo_q[MAG_W-1]};

	always_comb begin
		ua   = acc_q;
		ub   = '0;
		usub = 1'b0;
		case (state_q)
			ST_ACC: begin
				ub = {{(UW-SW){1'b0}}, hist_q[idx_q]};
			end
			ST_ZADD: begin
				ub = {{(UW-SW){z_q[SW-1]}}, z_q};
			end
			ST_ABS: begin
				ua   = '0;
				ub   = num_q;
				usub = num_q[UW-1];
			end
			ST_DIV: begin
				ua   = rem_sh;
				ub   = {{(UW-ZC_W){1'b0}}, zc_new};
				usub = 1'b1;
			end
			ST_CHK: begin
				// new average plus the stored entries that stay in the history
				ua = {{(UW-SW){1'b0}}, quo_q[SW-1:0]};
				ub = acc_q;
			end
			default: begin
				ua = acc_q;
			end
		endcase
	end

	// ---- evaluation of one request ----
	logic signed [ZW-1:0]   zadj;
	logic signed [SW:0]     dx, dy;
	logic [SW:0]            adx, ady;
	logic [SW-1:0]          ax, apx;
	logic [CW-1:0]          flip_lim;
	logic                   is_whip, flip_x, flip_y;
	logic                   chk_go, avg_ok, flip_clear;
	logic [MAP_DEPTH-1:0]   fmask;
	logic [UW-1:0]          avg_lim;
	logic                   whip_n, det_n;
	logic [TIMEOUT_W-1:0]   tmr_n;
	logic [MAP_DEPTH-1:0]   wb_n, fb_n;
	logic [MC_W-1:0]        wc_n, fc_n;

	always_comb begin
		zadj = {{2{z_q[SW-1]}}, z_q} - (fu_q ? FU_OFFSET : '0);
		dx   = {prev_x_q[SW-1], prev_x_q} - {x_q[SW-1], x_q};
		dy   = {prev_y_q[SW-1], prev_y_q} - {y_q[SW-1], y_q};
		adx  = dx[SW] ? (SW+1)'(-dx) : dx;
		ady  = dy[SW] ? (SW+1)'(-dy) : dy;
		ax   = x_q[SW-1] ? SW'(-x_q) : x_q;
		apx  = prev_x_q[SW-1] ? SW'(-prev_x_q) : prev_x_q;

		// |dx| * 10000 > -(range * 0.1285 * 10000) fails only for dx = 0 at zero range
		is_whip = (zadj < WHIP_LIM) && ((range_q != '0) || (dx != '0))
			&& (apx < SMALL_X) && (ax < SMALL_X);

		flip_lim = CW'(range_q) * CW'(FLIP_NUM);
		flip_x = ((x_q[SW-1] && !prev_x_q[SW-1] && prev_x_q != '0)
			|| (!x_q[SW-1] && x_q != '0 && prev_x_q[SW-1]))
			&& (CW'(adx) * CW'(FLIP_DEN) > flip_lim);
		flip_y = ((y_q[SW-1] && !prev_y_q[SW-1] && prev_y_q != '0)
			|| (!y_q[SW-1] && y_q != '0 && prev_y_q[SW-1]))
			&& (CW'(ady) * CW'(FLIP_DEN) > flip_lim);

		// average of the updated history against 5.0, without dividing
		avg_lim = UW'(zc_new) * UW'(AVG_Z_LIMIT);
		avg_ok  = $unsigned(chk_q) >= avg_lim;
		chk_go  = detect_q && (whip_cnt_q == MC_W'(MAP_DEPTH))
			&& whip_bits_q[MAP_DEPTH-1];

		// flips seen among the newest flip_count-1 entries
		for (int i = 0; i < MAP_DEPTH; i++) begin
			fmask[i] = (i + 1) < int'(flip_cnt_q);
		end
		flip_clear = (flip_bits_q & fmask) == '0;

		whip_n = 1'b0;
		det_n  = detect_q;
		tmr_n  = timer_q;
		wb_n   = whip_bits_q;
		wc_n   = whip_cnt_q;
		fb_n   = flip_bits_q;
		fc_n   = flip_cnt_q;

		if (kind_q) begin
			if (timer_q != '0) begin
				tmr_n = timer_q - TIMEOUT_W'(1);
				if (timer_q == TIMEOUT_W'(1)) begin
					det_n = 1'b0;
				end
			end
		end else if (ori_q) begin
			if (chk_go && avg_ok) begin
				det_n = 1'b0;
				tmr_n = '0;
				if (whip_bits_q[2:0] == 3'b000) begin
					wb_n   = '0;
					wc_n   = '0;
					whip_n = flip_clear;
				end
			end
			wc_n = ((wc_n > MC_W'(MAP_DEPTH - 1)) ? MC_W'(MAP_DEPTH - 1) : wc_n) + MC_W'(1);
			wb_n = {wb_n[MAP_DEPTH-2:0], is_whip};
			if (is_whip && !det_n && tmr_n == '0) begin
				tmr_n = (timeout_q == '0) ? TIMEOUT_W'(1) : timeout_q;
				det_n = 1'b1;
			end
			fc_n = ((fc_n > MC_W'(MAP_DEPTH - 1)) ? MC_W'(MAP_DEPTH - 1) : fc_n) + MC_W'(1);
			fb_n = {fb_n[MAP_DEPTH-2:0], flip_x || flip_y};
		end
	end

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q   <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEL_RANGE: range_q   <= cfg_data[RANGE_W-1:0];
				REG_TIMEOUT:     timeout_q <= cfg_data[TIMEOUT_W-1:0];
				default:         range_q   <= range_q;
			endcase
		end
	end

	// ---- sequencer and state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			z_count_q   <= '0;
			whip_bits_q <= '0;
			whip_cnt_q  <= '0;
			flip_bits_q <= '0;
			flip_cnt_q  <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			detect_q    <= 1'b0;
			timer_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken at this edge
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser) begin
							state_q <= ST_EVAL;
						end else if (zc_in == '0) begin
							state_q <= ST_ZADD;
						end else begin
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					if (ZC_W'(idx_q) == zc_sat_q - ZC_W'(1)) begin
						state_q <= ST_ZADD;
					end
				end
				ST_ZADD: state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_DIV;
				ST_DIV: begin
					if (dcnt_q == DC_W'(MAG_W - 1)) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: state_q <= ST_EVAL;
				ST_EVAL: begin
					// hold here while the previous result still waits
					if (out_free) begin
						state_q     <= ST_IDLE;
						whip_bits_q <= wb_n;
						whip_cnt_q  <= wc_n;
						flip_bits_q <= fb_n;
						flip_cnt_q  <= fc_n;
						detect_q    <= det_n;
						timer_q     <= tmr_n;
						if (!kind_q) begin
							z_count_q <= zc_new;
							if (ori_q) begin
								prev_x_q <= x_q;
								prev_y_q <= y_q;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q   <= s_tuser;
				x_q      <= s_tdata[SW-1:0];
				y_q      <= s_tdata[2*SW-1:SW];
				z_q      <= s_tdata[3*SW-1:2*SW];
				ori_q    <= s_tdata[3*SW];
				fu_q     <= s_tdata[3*SW+1];
				zc_sat_q <= zc_in;
				idx_q    <= '0;
				acc_q    <= '0;
			end
			ST_ACC: begin
				acc_q <= ur;
				idx_q <= idx_q + IDX_W'(1);
			end
			ST_ZADD: num_q <= ur;
			ST_ABS: begin
				quo_q  <= ur[MAG_W-1:0];
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				dcnt_q <= dcnt_q + DC_W'(1);
				if (!ur[UW-1]) begin
					rem_q <= ur;
					quo_q <= {quo_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[MAG_W-2:0], 1'b0};
				end
			end
			ST_CHK: chk_q <= ur;
			ST_EVAL: begin
				if (out_free) begin
					out_whip_q <= whip_n;
					out_det_q  <= det_n;
					if (!kind_q) begin
						// newest first; |average| fits the sample width
						for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
							hist_q[i] <= hist_q[i-1];
						end
						hist_q[0] <= quo_q[SW-1:0];
					end
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	// ---- assertions ----
	`include "whip_gesture_detector_core_assert.svh"

	`WGD_ASSERT(a_detect_timer, detect_q == (timer_q != '0), "detect flag and timer disagree")
	`WGD_ASSERT(a_zcount_cap, z_count_q <= ZC_W'(HISTORY_DEPTH), "z history count overflow")
	`WGD_ASSERT_NEXT(a_busy_after_req, accept, !s_tready, "request taken while busy")
	`WGD_ASSERT_NEXT(a_result_from_eval, state_q != ST_EVAL && !m_tready && !out_valid_q,
		!out_valid_q, "result appeared outside evaluation")

endmodule

// File: tb/sv/whip_gesture_detector_core_test.sv
// Self-checking stream testbench for the whip gesture detector core.
`timescale 1ns / 1ps

module whip_gesture_detector_core_test;
	import wgd_pkg::*;

	// Geometry of the default build
	localparam int HIST_N   = 5;
	localparam int MAP_N    = 6;
	localparam int MAP_MASK = (1 << MAP_N) - 1;
	localparam int IN_BITS  = 56;

	// Q7.8 thresholds, kept separate from the RTL's own copies
	localparam longint Q_FACE_UP = 2509;   // 9.8
	localparam longint Q_WHIP_Z  = -2816;  // -11.0
	localparam longint Q_SMALL_X = 1792;   // 7.0
	localparam longint Q_AVG_Z   = 1280;   // 5.0

	// One input request: kind travels on tuser, the rest in tdata
	typedef struct packed {
		logic        kind;
		logic        face_up;
		logic        orient;
		logic [15:0] az;
		logic [15:0] ay;
		logic [15:0] ax;
	} gesture_req_t;

	typedef struct packed {
		logic whip;
		logic detecting;
	} outcome_t;

	typedef enum int {GEST_CLEAN, GEST_FLIP, GEST_RECENT, GEST_BLIND, GEST_TICKS} gesture_e;

	// Tracks the detector state and queues the outcome each request must give.
	class gesture_tracker;
		longint   range_q;
		longint   timeout_q;
		longint   z_hist[HIST_N];
		int       z_cnt;
		int       whip_bits;
		int       whip_cnt;
		int       flip_bits;
		int       flip_cnt;
		longint   last_x;
		longint   last_y;
		bit       detect;
		longint   timer_left;
		outcome_t outcome_q[$];
		int       errors;

		function new();
			range_q    = 0;
			timeout_q  = 850;
			z_cnt      = 0;
			whip_bits  = 0;
			whip_cnt   = 0;
			flip_bits  = 0;
			flip_cnt   = 0;
			last_x     = 0;
			last_y     = 0;
			detect     = 1'b0;
			timer_left = 0;
			errors     = 0;
			foreach (z_hist[i])
				z_hist[i] = 0;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			if (idx == REG_ACCEL_RANGE)
				range_q = longint'(v & 16'h7FFF);
			else
				timeout_q = longint'(v);
		endfunction

		function longint magnitude(longint v);
			return (v < 0) ? -v : v;
		endfunction

		// Oldest whip bit reached while detecting: decide on the gesture
		function bit whip_check();
			longint sum;
			int     m;
			bit     ok;
			sum = 0;
			for (int i = 0; i < z_cnt && i < HIST_N; i++)
				sum += z_hist[i];
			if (z_cnt == 0 || sum / longint'(z_cnt) < Q_AVG_Z)
				return 1'b0;
			if ((whip_bits & 7) != 0) begin
				// another whip-like sample too recent: abandon this one
				detect     = 1'b0;
				timer_left = 0;
				return 1'b0;
			end
			ok = 1'b1;
			if (flip_cnt > 1) begin
				m = (1 << (flip_cnt - 1)) - 1;
				if ((flip_bits & m) != 0)
					ok = 1'b0;
			end
			detect     = 1'b0;
			whip_bits  = 0;
			whip_cnt   = 0;
			timer_left = 0;
			return ok;
		endfunction

		function void take_request(gesture_req_t r);
			outcome_t o;
			longint   x, y, z, sum, avg, dx, dy;
			bit       is_whip, flip_x, flip_y;
			o.whip = 1'b0;
			if (r.kind) begin
				// timer tick
				if (timer_left > 0) begin
					timer_left--;
					if (timer_left == 0)
						detect = 1'b0;
				end
			end else begin
				x = longint'($signed(r.ax));
				y = longint'($signed(r.ay));
				z = longint'($signed(r.az));
				if (z_cnt > HIST_N - 1)
					z_cnt = HIST_N - 1;
				sum = z;
				for (int i = 0; i < z_cnt; i++)
					sum += z_hist[i];
				avg = sum / longint'(z_cnt + 1);
				for (int i = z_cnt; i > 0; i--)
					z_hist[i] = z_hist[i - 1];
				z_hist[0] = magnitude(avg);
				z_cnt++;
				if (r.orient) begin
					dx = last_x - x;
					dy = last_y - y;
					if (r.face_up)
						z -= Q_FACE_UP;
					if (detect && whip_cnt > MAP_N - 1 && ((whip_bits >> (MAP_N - 1)) & 1) != 0)
						o.whip = whip_check();
					is_whip = z < Q_WHIP_Z && magnitude(dx) * 10000 > -(range_q * 1285) &&
						magnitude(last_x) < Q_SMALL_X && magnitude(x) < Q_SMALL_X;
					whip_bits = ((whip_bits << 1) | int'(is_whip)) & MAP_MASK;
					whip_cnt  = ((whip_cnt > MAP_N - 1) ? MAP_N - 1 : whip_cnt) + 1;
					if (is_whip && !detect && timer_left == 0) begin
						timer_left = (timeout_q == 0) ? 1 : timeout_q;
						detect     = 1'b1;
					end
					flip_x = ((x < 0 && last_x > 0) || (x > 0 && last_x < 0)) &&
						magnitude(dx) * 10 > range_q * 7;
					flip_y = ((y < 0 && last_y > 0) || (y > 0 && last_y < 0)) &&
						magnitude(dy) * 10 > range_q * 7;
					flip_bits = ((flip_bits << 1) | int'(flip_x || flip_y)) & MAP_MASK;
					flip_cnt  = ((flip_cnt > MAP_N - 1) ? MAP_N - 1 : flip_cnt) + 1;
					last_x = x;
					last_y = y;
				end
			end
			o.detecting = detect;
			outcome_q.push_back(o);
		endfunction

		task report(string msg);
			$display("%0t ns mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_outcome(logic [7:0] d);
			outcome_t o;
			if (outcome_q.size() == 0) begin
				report($sformatf("result %h with no request waiting", d));
			end else begin
				o = outcome_q.pop_front();
				if (d[0] !== o.whip)
					report($sformatf("whip_detected %b, wanted %b", d[0], o.whip));
				if (d[1] !== o.detecting)
					report($sformatf("detecting %b, wanted %b", d[1], o.detecting));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_BITS-1:0]   s_tdata;   // accel_x, accel_y, accel_z, orientation_known, face_up
	logic                 s_tuser;   // kind: 0 sample, 1 timer tick
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;   // whip_detected, detecting
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	gesture_tracker tracker = new();

	int sent;          // requests accepted so far
	bit quiet;         // no random gaps on either side while set
	int hold_req;      // long receiver hold-off, handed over at a rising edge
	bit result_taken;  // a result was taken at the last rising edge

	whip_gesture_detector_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Results are sampled at the rising edge, before the core updates them.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_outcome(m_tdata);
			result_taken = 1'b1;
		end
	end

	// Receiver: a fresh wait after each result, plus the occasional long hold-off
	// which it counts itself while the sender keeps offering requests.
	initial begin
		int rx_gap;
		int hold_cnt;
		m_tready     = 1'b0;
		result_taken = 1'b0;
		rx_gap       = 0;
		hold_cnt     = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_cnt = hold_req;
				hold_req = 0;
			end
			if (result_taken) begin
				result_taken = 1'b0;
				rx_gap = quiet ? 0 : $urandom_range(0, 16);
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Offer one request after a random gap and hold it until it is taken.
	// tvalid stays high afterwards so back-to-back requests need no toggle.
	task automatic send_req(input gesture_req_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = r.kind;
		s_tdata  = {6'd0, r.face_up, r.orient, r.az, r.ay, r.ax};
		do @(posedge clk); while (!s_tready);
		tracker.take_request(r);
		sent++;
	endtask

	task automatic send_sample(input int x, input int y, input int z, input logic orient,
		input logic face);
		gesture_req_t r;
		r.kind    = 1'b0;
		r.face_up = face;
		r.orient  = orient;
		r.ax      = x[15:0];
		r.ay      = y[15:0];
		r.az      = z[15:0];
		send_req(r);
	endtask

	task automatic send_tick();
		send_req('{kind: 1'b1, default: '0});
	endtask

	// Anything at all, ticks included, every bit free
	task automatic send_noise();
		gesture_req_t r;
		r.kind    = ($urandom_range(0, 3) == 0);
		r.face_up = 1'($urandom_range(0, 1));
		r.orient  = 1'($urandom_range(0, 1));
		r.ax      = 16'($urandom);
		r.ay      = 16'($urandom);
		r.az      = 16'($urandom);
		send_req(r);
	endtask

	function automatic int small_x(int sx);
		int m;
		m = $urandom_range(1, 1791);
		return sx * m;
	endfunction

	function automatic int big_y();
		return int'($urandom_range(1, 32767));
	endfunction

	// Mostly large positive z so the history average clears 5.0, now and then not
	function automatic int filler_z();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom_range(0, 4816)) - 2816;
		return int'($urandom_range(1500, 32767));
	endfunction

	// Lead sample, whip-like sample, five fillers and a trigger sample.
	// A variant other than the clean one breaks the sequence in one place or pads it with ticks.
	task automatic gesture(input gesture_e variant);
		int   sx;
		int   wz;
		int   nticks;
		logic face;
		sx   = ($urandom_range(0, 1) != 0) ? 1 : -1;
		face = 1'($urandom_range(0, 1));
		send_sample(small_x(sx), big_y(), filler_z(), 1'b1, 1'b0);
		// face up z is offset by 9.8 before the compare
		wz = face ? -int'($urandom_range(308, 32768)) : -int'($urandom_range(2817, 32768));
		send_sample(small_x(sx), big_y(), wz, 1'b1, face);
		for (int i = 0; i < 6; i++) begin
			nticks = (variant == GEST_TICKS) ? $urandom_range(1, 3) :
				int'($urandom_range(0, 7) == 0);
			repeat (nticks) send_tick();
			if (variant == GEST_FLIP && i == 2)
				send_sample(small_x(sx), -big_y(), filler_z(), 1'b1, 1'b0);
			else if (variant == GEST_RECENT && i == 3)
				send_sample(small_x(sx), big_y(), -int'($urandom_range(2817, 32768)), 1'b1, 1'b0);
			else if (variant == GEST_BLIND && i == 1)
				send_sample(small_x(sx), big_y(), filler_z(), 1'b0, 1'b0);
			else
				send_sample(small_x(sx), big_y(), filler_z(), 1'b1, 1'b0);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.write_reg(idx, v);
	endtask

	// Stop offering and wait for every outstanding result; each request gives
	// exactly one, so the core is idle once the queue is empty.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned range_val, input int unsigned ticks_val,
		input int count, input bit calm, input bit squeeze);
		int stop_at;
		settle();
		write_reg(REG_ACCEL_RANGE, range_val[CFG_W-1:0]);
		write_reg(REG_TIMEOUT, ticks_val[CFG_W-1:0]);
		@(posedge clk);
		quiet = calm;
		if (squeeze)
			hold_req = 400;
		stop_at = sent + count;
		while (sent < stop_at) begin
			if ($urandom_range(0, 3) != 0)
				gesture(gesture_e'($urandom_range(0, 4)));
			else
				send_noise();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		sent      = 0;
		quiet     = 1'b0;
		hold_req  = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset settings: idle tick, field extremes,
		// unsaturated face-up offset, a clean gesture and a flipped one.
		send_tick();
		send_sample(-32768, -32768, -32768, 1'b0, 1'b0);
		send_sample(32767, 32767, 32767, 1'b0, 1'b1);
		send_sample(32767, -32768, -32768, 1'b1, 1'b1);
		send_sample(-32768, 32767, 32767, 1'b1, 1'b0);
		gesture(GEST_CLEAN);
		gesture(GEST_FLIP);

		// Zero timeout behaves as one tick: the window closes on the first tick
		settle();
		write_reg(REG_TIMEOUT, '0);
		send_sample(10, 100, 3000, 1'b1, 1'b0);
		send_sample(20, 100, -4000, 1'b1, 1'b0);
		send_tick();
		send_tick();

		// Random phases over several register settings, extremes included;
		// the range write with bit 15 set checks that the top bit is dropped.
		run_phase(32767, 65535, 100, 1'b0, 1'b0);
		run_phase(0, 850, 90, 1'b1, 1'b0);
		run_phase($urandom_range(0, 32767), $urandom_range(1, 2000), 90, 1'b1, 1'b1);
		run_phase(32'h0000_FFFF, 1, 90, 1'b0, 1'b0);
		run_phase($urandom_range(0, 32767), $urandom_range(100, 65535), 120, 1'b0, 1'b0);
		run_phase(0, 3, 90, 1'b0, 1'b0);

		settle();
		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
